[hdl/wfss_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted fair stream scheduler package
// Shared widths, codes, sequencer states, memory request type and helpers.
// ----------------------------------------------------------------------------
package wfss_pkg;

	localparam int VT_W   = 64;
	localparam int IW_W   = 40;
	localparam int STR_W  = VT_W + IW_W;
	localparam int ADDR_W = 10;
	localparam int PROD_W = 56;

	localparam int DEF_NUM_STREAMS = 16;
	localparam int DEF_FRAC_BITS   = 16;

	localparam logic [1:0] ACT_SELECT = 2'd0;
	localparam logic [1:0] ACT_REPORT = 2'd1;
	localparam logic [1:0] ACT_SETPRI = 2'd2;
	localparam logic [1:0] ACT_DREADY = 2'd3;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_EMPTY   = 2'd1;
	localparam logic [1:0] ST_IGNORED = 2'd2;

	localparam logic REG_INTERLEAVE = 1'b0;
	localparam logic REG_MAX_PAYLOAD = 1'b1;

	localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1200;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_SEL,
		S_MUL,
		S_ADD1,
		S_ADD2,
		S_WR,
		S_DIV,
		S_RESULT
	} state_t;

	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              fin_we;
		logic              str_we;
		logic [ADDR_W-1:0] wr_addr;
	} mem_req_t;

	function automatic logic [VT_W-1:0] sat_add(input logic [VT_W-1:0] a,
		input logic [VT_W-1:0] b);
		logic [VT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[VT_W] ? {VT_W{1'b1}} : s[VT_W-1:0];
	endfunction

endpackage

[hdl/wfss_state_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream state memories
// Finish time memory and stream memory {virtual time, inverse weight}, each
// with one write port and a registered read port sharing one read address.
// ----------------------------------------------------------------------------
module wfss_state_mem #(
	parameter int NUM_STREAMS = wfss_pkg::DEF_NUM_STREAMS
) (
	input  logic                       clk,
	input  wfss_pkg::mem_req_t         req,
	input  logic [wfss_pkg::VT_W-1:0]  fin_wdata,
	input  logic [wfss_pkg::STR_W-1:0] str_wdata,
	output logic [wfss_pkg::VT_W-1:0]  fin_rdata,
	output logic [wfss_pkg::STR_W-1:0] str_rdata
);
	import wfss_pkg::*;

	localparam int SW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;

	logic [VT_W-1:0]  fin_mem [NUM_STREAMS];
	logic [STR_W-1:0] str_mem [NUM_STREAMS];

	always_ff @(posedge clk) begin
		if (req.fin_we) begin
			fin_mem[req.wr_addr[SW-1:0]] <= fin_wdata;
		end
		if (req.rd_en) begin
			fin_rdata <= fin_mem[req.rd_addr[SW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (req.str_we) begin
			str_mem[req.wr_addr[SW-1:0]] <= str_wdata;
		end
		if (req.rd_en) begin
			str_rdata <= str_mem[req.rd_addr[SW-1:0]];
		end
	end

endmodule

[hdl/wfss_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reciprocal weight divider
// Restoring divider, one quotient bit per cycle, 16-bit divisor.
// ----------------------------------------------------------------------------
module wfss_div #(
	parameter int NUM_W = 18
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] numer,
	input  logic [15:0]      denom,
	output logic             done,
	output logic [NUM_W-1:0] quot
);
	import wfss_pkg::*;

	localparam int CW = $clog2(NUM_W + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [16:0]   rem_q;
	logic [NUM_W-1:0] num_q;
	logic [15:0]   den_q;
	logic [16:0]   trial;
	logic          fits;

	assign trial = {rem_q[15:0], num_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= numer;
			den_q <= denom;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, den_q}) : trial;
			num_q <= {num_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = num_q;

endmodule

[hdl/weighted_fair_stream_scheduler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted fair stream scheduler
// Grants the active stream with the smallest virtual finish time, tracks
// per-stream virtual time in on-chip memories, updated on reports and data ready.
//
//   channel   handshake            payload
//   -------   ------------------   ------------------------------------------
//   in        in_valid/in_ready    action stream_id produced payload_length
//                                  is_end bytes_next priority_req
//   out       out_valid/out_ready  grant_valid grant_stream status
//   cfg       cfg_we               cfg_index cfg_data
//
// Select reads the finish time memory once per stream, one read per cycle.
// Report and data ready run after the read at acceptance through multiply,
// two saturating adds, write and result; set priority waits for the
// bit-serial divider. After reset a clearing pass over all NUM_STREAMS
// entries initializes the memories with in_ready low. A new request is
// taken while a result waits in the output register; a second result waits
// for out_ready.
// ----------------------------------------------------------------------------
module weighted_fair_stream_scheduler #(
	parameter int NUM_STREAMS = wfss_pkg::DEF_NUM_STREAMS,
	parameter int FRAC_BITS   = wfss_pkg::DEF_FRAC_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [3:0]  stream_id,
	input  logic        produced,
	input  logic [15:0] payload_length,
	input  logic        is_end,
	input  logic [31:0] bytes_next,
	input  logic [15:0] priority_req,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        grant_valid,
	output logic [3:0]  grant_stream,
	output logic [1:0]  status,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import wfss_pkg::*;

	localparam int SW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
	localparam int NW = ((FRAC_BITS > 15) ? FRAC_BITS : 15) + 2;
	localparam logic [VT_W-1:0] ONE_FIXED = VT_W'(1) << FRAC_BITS;
	localparam logic [IW_W-1:0] IW_MAX = {IW_W{1'b1}};
	localparam logic [63:0] IW_ZERO_RAW = 64'd1000000 << FRAC_BITS;
	localparam logic [IW_W-1:0] IW_ZERO =
		(IW_ZERO_RAW > 64'(IW_MAX)) ? IW_MAX : IW_ZERO_RAW[IW_W-1:0];
	localparam logic [IW_W-1:0] IW_RESET = IW_W'(1) << (FRAC_BITS - 8);

	state_t state_q, state_d;
	mem_req_t req;
	logic [VT_W-1:0]  fin_wdata, fin_rdata;
	logic [STR_W-1:0] str_wdata, str_rdata;

	logic        ilv_q;
	logic [15:0] cap_q;

	logic [SW-1:0] clr_q;
	logic [SW:0]   scan_q;
	logic          vld_s1;
	logic [SW-1:0] idx_s1;
	logic          any_q, cur_act_q;
	logic [SW-1:0] best_q;
	logic [VT_W-1:0] best_fin_q;

	logic [SW-1:0] cur_q;
	logic          cur_valid_q, mid_q, latch_q;
	logic [VT_W-1:0] gvt_q;

	logic [1:0]  act_q;
	logic [3:0]  sid_q;
	logic [15:0] plen_q;
	logic        end_q;
	logic [31:0] bytes_q;
	logic [15:0] prio_q;

	logic [VT_W-1:0] vt_q, vt1_q, fin_q;
	logic [IW_W-1:0] iw_q;
	logic [PROD_W-1:0] p1_q, p2_q;

	logic [1:0]  res_st_q;
	logic        res_gv_q;
	logic [3:0]  res_gs_q;
	logic        out_valid_q, grant_valid_q;
	logic [3:0]  grant_stream_q;
	logic [1:0]  status_q;

	logic        accept, sid_bad, resched, activate, out_free, scan_last;
	logic        div_start, div_done;
	logic [NW-1:0] div_numer, div_quot;
	logic [IW_W-1:0] new_iw;
	logic [15:0] cap_eff, n_bytes;
	logic [IW_W-1:0] rd_iw;

	assign accept    = in_valid && in_ready;
	assign sid_bad   = 32'(stream_id) >= NUM_STREAMS;
	assign resched   = ilv_q || !mid_q;
	assign activate  = (act_q == ACT_REPORT) ? (latch_q && bytes_q != '0) : 1'b1;
	assign out_free  = !out_valid_q || out_ready;
	assign scan_last = vld_s1 && idx_s1 == SW'(NUM_STREAMS - 1);
	assign cap_eff   = (cap_q == '0) ? 16'd1 : cap_q;
	assign n_bytes   = (bytes_q < 32'(cap_eff)) ? bytes_q[15:0] : cap_eff;
	assign rd_iw     = str_rdata[IW_W-1:0];
	assign div_numer = (NW'(1) << FRAC_BITS) + NW'(priority_req[15:1]);
	assign new_iw    = (prio_q == '0) ? IW_ZERO :
		(div_quot == '0) ? IW_W'(1) : IW_W'(div_quot);

	wfss_state_mem #(.NUM_STREAMS(NUM_STREAMS)) u_mem (
		.clk       (clk),
		.req       (req),
		.fin_wdata (fin_wdata),
		.str_wdata (str_wdata),
		.fin_rdata (fin_rdata),
		.str_rdata (str_rdata)
	);

	wfss_div #(.NUM_W(NW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (div_numer),
		.denom  (priority_req),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		req         = '0;
		fin_wdata   = '0;
		str_wdata   = '0;
		div_start   = 1'b0;
		in_ready    = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				req.fin_we  = 1'b1;
				req.str_we  = 1'b1;
				req.wr_addr = ADDR_W'(clr_q);
				str_wdata   = {{VT_W{1'b0}}, IW_RESET};
				if (clr_q == SW'(NUM_STREAMS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (action)
						ACT_SELECT: state_d = S_SCAN;
						ACT_REPORT: begin
							req.rd_addr = ADDR_W'(cur_q);
							if (!cur_valid_q || !produced) begin
								state_d = S_RESULT;
							end else begin
								req.rd_en = 1'b1;
								state_d   = S_MUL;
							end
						end
						ACT_SETPRI: begin
							req.rd_addr = ADDR_W'(stream_id);
							if (sid_bad) begin
								state_d = S_RESULT;
							end else begin
								req.rd_en = 1'b1;
								div_start = 1'b1;
								state_d   = S_DIV;
							end
						end
						ACT_DREADY: begin
							req.rd_addr = ADDR_W'(stream_id);
							if (sid_bad) begin
								state_d = S_RESULT;
							end else begin
								req.rd_en = 1'b1;
								state_d   = S_MUL;
							end
						end
						default: state_d = S_RESULT;
					endcase
				end
			end
			S_SCAN: begin
				req.rd_en   = scan_q < (SW + 1)'(NUM_STREAMS);
				req.rd_addr = ADDR_W'(scan_q[SW-1:0]);
				if (scan_last) begin
					state_d = S_SEL;
				end
			end
			S_SEL: begin
				req.fin_we  = any_q && resched;
				req.wr_addr = ADDR_W'(best_q);
				state_d     = S_RESULT;
			end
			S_MUL: begin
				if (act_q == ACT_DREADY && fin_rdata != '0) begin
					state_d = S_RESULT;
				end else if (act_q == ACT_DREADY && bytes_q == '0) begin
					state_d = S_RESULT;
				end else begin
					state_d = S_ADD1;
				end
			end
			S_ADD1: state_d = S_ADD2;
			S_ADD2: state_d = S_WR;
			S_WR: begin
				req.str_we  = 1'b1;
				req.wr_addr = (act_q == ACT_REPORT) ? ADDR_W'(cur_q) : ADDR_W'(sid_q);
				str_wdata   = {vt1_q, iw_q};
				if (activate) begin
					req.fin_we = 1'b1;
					fin_wdata  = fin_q;
				end else begin
					req.fin_we = !latch_q && bytes_q == '0;
				end
				state_d = S_RESULT;
			end
			S_DIV: begin
				if (div_done) begin
					req.str_we  = 1'b1;
					req.wr_addr = ADDR_W'(sid_q);
					str_wdata   = {str_rdata[STR_W-1:IW_W], new_iw};
					state_d     = S_RESULT;
				end
			end
			S_RESULT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ilv_q <= 1'b0;
			cap_q <= MAX_PAYLOAD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INTERLEAVE:  ilv_q <= cfg_data[0];
				REG_MAX_PAYLOAD: cap_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			scan_q      <= '0;
			vld_s1      <= 1'b0;
			cur_q       <= '0;
			cur_valid_q <= 1'b0;
			mid_q       <= 1'b0;
			latch_q     <= 1'b0;
			gvt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == S_IDLE) begin
				scan_q <= '0;
			end else if (req.rd_en && state_q == S_SCAN) begin
				scan_q <= scan_q + 1'b1;
			end
			vld_s1 <= state_q == S_SCAN && req.rd_en;
			if (state_q == S_SEL && any_q) begin
				if (resched) begin
					cur_q       <= best_q;
					cur_valid_q <= 1'b1;
					latch_q     <= 1'b1;
				end else if (cur_valid_q && cur_act_q) begin
					latch_q <= 1'b0;
				end
			end
			if (state_q == S_WR && act_q == ACT_REPORT) begin
				gvt_q <= vt1_q;
				mid_q <= !end_q;
			end
			if (state_q == S_RESULT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_q[SW-1:0];
		if (accept) begin
			act_q    <= action;
			sid_q    <= stream_id;
			plen_q   <= payload_length;
			end_q    <= is_end;
			bytes_q  <= bytes_next;
			prio_q   <= priority_req;
			any_q    <= 1'b0;
			cur_act_q <= 1'b0;
			res_gv_q <= 1'b0;
			res_gs_q <= '0;
			res_st_q <= ((action == ACT_REPORT && !cur_valid_q) ||
				((action == ACT_SETPRI || action == ACT_DREADY) && sid_bad)) ?
				ST_IGNORED : ST_DONE;
		end
		if (vld_s1) begin
			if (fin_rdata != '0 && (!any_q || fin_rdata < best_fin_q)) begin
				any_q      <= 1'b1;
				best_q     <= idx_s1;
				best_fin_q <= fin_rdata;
			end
			if (idx_s1 == cur_q) begin
				cur_act_q <= fin_rdata != '0;
			end
		end
		if (state_q == S_SEL) begin
			if (!any_q) begin
				res_st_q <= ST_EMPTY;
			end else if (resched) begin
				res_gv_q <= 1'b1;
				res_gs_q <= 4'(best_q);
			end else if (cur_valid_q && cur_act_q) begin
				res_gv_q <= 1'b1;
				res_gs_q <= 4'(cur_q);
			end else begin
				res_st_q <= ST_IGNORED;
			end
		end
		if (state_q == S_MUL) begin
			vt_q <= str_rdata[STR_W-1:IW_W];
			iw_q <= rd_iw;
			p1_q <= PROD_W'(plen_q) * PROD_W'(rd_iw);
			p2_q <= PROD_W'(n_bytes) * PROD_W'(rd_iw);
			if (act_q == ACT_DREADY && fin_rdata != '0) begin
				res_st_q <= ST_IGNORED;
			end
		end
		if (state_q == S_ADD1) begin
			if (act_q == ACT_REPORT) begin
				vt1_q <= sat_add(vt_q, ilv_q ? VT_W'(p1_q) : ONE_FIXED);
			end else begin
				vt1_q <= gvt_q;
			end
		end
		if (state_q == S_ADD2) begin
			fin_q <= sat_add(vt1_q, ilv_q ? VT_W'(p2_q) : ONE_FIXED);
		end
		if (state_q == S_RESULT && out_free) begin
			grant_valid_q  <= res_gv_q;
			grant_stream_q <= res_gs_q;
			status_q       <= res_st_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign grant_valid  = grant_valid_q;
	assign grant_stream = grant_stream_q;
	assign status       = status_q;

	a_grant_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && grant_valid |-> status == ST_DONE)
		else $error("grant with nonzero status");

	a_no_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !grant_valid |-> grant_stream == 4'd0)
		else $error("grant_stream set without grant");

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("request taken while busy");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !(req.fin_we || req.str_we))
		else $error("memory write while idle");

endmodule

[verif/weighted_fair_stream_scheduler_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted fair stream scheduler checker
// Watches the request, result and register channels, tracks finish times,
// virtual times and inverse weights per stream, and compares every result
// with the oldest predicted grant.
// ----------------------------------------------------------------------------
module weighted_fair_stream_scheduler_chk #(
	parameter int NUM_STREAMS = wfss_pkg::DEF_NUM_STREAMS,
	parameter int FRAC_BITS   = wfss_pkg::DEF_FRAC_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  action,
	input  logic [3:0]  stream_id,
	input  logic        produced,
	input  logic [15:0] payload_length,
	input  logic        is_end,
	input  logic [31:0] bytes_next,
	input  logic [15:0] priority_req,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        grant_valid,
	input  logic [3:0]  grant_stream,
	input  logic [1:0]  status,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	output int          err_count,
	output int          pending
);
	import wfss_pkg::*;

	localparam logic [63:0] ONE_FIX = 64'd1 << FRAC_BITS;
	localparam logic [63:0] IW_LIM  = (64'd1 << IW_W) - 64'd1;

	typedef struct packed {
		logic       gv;
		logic [3:0] gs;
		logic [1:0] st;
	} grant_t;

	grant_t      grant_q[$];
	logic [63:0] fin_time[NUM_STREAMS];
	logic [63:0] str_vtime[NUM_STREAMS];
	logic [63:0] inv_wt[NUM_STREAMS];
	logic [63:0] glob_vtime;
	logic [3:0]  cur_stream;
	logic        cur_valid, mid_msg, resched;
	logic        ilv_en;
	logic [15:0] max_bytes;

	function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? {64{1'b1}} : s[63:0];
	endfunction

	function automatic logic [63:0] recip(input logic [15:0] p);
		logic [63:0] r;
		if (p == 16'd0) begin
			r = 64'd1000000 << FRAC_BITS;
		end else begin
			r = (ONE_FIX + 64'(p >> 1)) / 64'(p);
			if (r == 64'd0)
				r = 64'd1;
		end
		return (r > IW_LIM) ? IW_LIM : r;
	endfunction

	function automatic logic [63:0] vtime_after(input int s, input logic [63:0] base,
		input logic [63:0] n);
		if (ilv_en)
			return add_sat(base, n * inv_wt[s]);
		return add_sat(base, ONE_FIX);
	endfunction

	task automatic activate(input int s, input logic [31:0] bytes);
		logic [63:0] cap, n;
		cap = (max_bytes == 16'd0) ? 64'd1 : 64'(max_bytes);
		n = (64'(bytes) < cap) ? 64'(bytes) : cap;
		str_vtime[s] = glob_vtime;
		fin_time[s] = vtime_after(s, glob_vtime, n);
	endtask

	task automatic predict_grant(output grant_t g);
		int best;
		bit any;
		g = '0;
		best = 0;
		any = 0;
		case (action)
		ACT_SELECT: begin
			for (int i = 0; i < NUM_STREAMS; i++)
				if (fin_time[i] != 0 && (!any || fin_time[i] < fin_time[best])) begin
					best = i;
					any = 1;
				end
			if (!any) begin
				g.st = ST_EMPTY;
			end else if (ilv_en || !mid_msg) begin
				cur_stream = best[3:0];
				cur_valid = 1'b1;
				fin_time[best] = '0;
				resched = 1'b1;
				g.gv = 1'b1;
				g.gs = best[3:0];
			end else if (cur_valid && fin_time[cur_stream] != 0) begin
				resched = 1'b0;
				g.gv = 1'b1;
				g.gs = cur_stream;
			end else begin
				g.st = ST_IGNORED;
			end
		end
		ACT_REPORT: begin
			if (!cur_valid) begin
				g.st = ST_IGNORED;
			end else if (produced) begin
				str_vtime[cur_stream] = vtime_after(cur_stream, str_vtime[cur_stream],
					64'(payload_length));
				mid_msg = !is_end;
				glob_vtime = str_vtime[cur_stream];
				if (resched && bytes_next != 0)
					activate(cur_stream, bytes_next);
				else if (!resched && bytes_next == 0)
					fin_time[cur_stream] = '0;
			end
		end
		ACT_SETPRI: begin
			inv_wt[stream_id] = recip(priority_req);
		end
		default: begin
			if (fin_time[stream_id] != 0)
				g.st = ST_IGNORED;
			else if (bytes_next != 0)
				activate(stream_id, bytes_next);
		end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		grant_t g, e;
		if (!arst_n) begin
			for (int i = 0; i < NUM_STREAMS; i++) begin
				fin_time[i] = '0;
				str_vtime[i] = '0;
				inv_wt[i] = recip(16'd256);
			end
			glob_vtime = '0;
			cur_stream = '0;
			cur_valid = 1'b0;
			mid_msg = 1'b0;
			resched = 1'b0;
			ilv_en = 1'b0;
			max_bytes = MAX_PAYLOAD_RST;
			grant_q.delete();
			err_count <= 0;
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (grant_q.size() == 0) begin
					if (err_count < 10)
						$display("unexpected result: gv %0d gs %0d st %0d",
							grant_valid, grant_stream, status);
					err_count <= err_count + 1;
				end else begin
					e = grant_q.pop_front();
					if (grant_valid !== e.gv || grant_stream !== e.gs || status !== e.st) begin
						if (err_count < 10)
							$display("mismatch: exp gv %0d gs %0d st %0d, got gv %0d gs %0d st %0d",
								e.gv, e.gs, e.st, grant_valid, grant_stream, status);
						err_count <= err_count + 1;
					end
				end
			end
			if (in_valid && in_ready) begin
				predict_grant(g);
				grant_q.push_back(g);
			end
			if (cfg_we) begin
				if (cfg_index == REG_INTERLEAVE)
					ilv_en = cfg_data[0];
				else
					max_bytes = cfg_data;
			end
			pending <= grant_q.size();
		end
	end
endmodule

[verif/weighted_fair_stream_scheduler_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted fair stream scheduler testbench
// Drives directed and random select, report, priority and data ready requests
// through eight register settings under varying sender and receiver idling;
// the checker predicts each grant and counts mismatches.
// ----------------------------------------------------------------------------
module weighted_fair_stream_scheduler_tb;
	import wfss_pkg::*;

	localparam int STALL_LIMIT = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  action = ACT_SELECT;
	logic [3:0]  stream_id = '0;
	logic        produced = 1'b0;
	logic [15:0] payload_length = '0;
	logic        is_end = 1'b0;
	logic [31:0] bytes_next = '0;
	logic [15:0] priority_req = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        grant_valid;
	logic [3:0]  grant_stream;
	logic [1:0]  status;
	logic        cfg_we = 1'b0;
	logic        cfg_index = REG_INTERLEAVE;
	logic [15:0] cfg_data = '0;
	int          err_count, pending;
	int          idle_mode = 0;
	int          stall_cycles = 0;
	logic [1:0]  last_action = ACT_REPORT;

	always #1 clk = ~clk;

	weighted_fair_stream_scheduler DUT (.*);

	weighted_fair_stream_scheduler_chk chk (.*);

	always @(negedge clk)
		out_ready <= (idle_mode == 2 || idle_mode == 3) ?
			($urandom_range(99) >= ((idle_mode == 2) ? 87 : 19)) : 1'b1;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic send_req(input logic [1:0] act, input logic [3:0] sid, input logic prod,
		input logic [15:0] plen, input logic endm, input logic [31:0] nxt,
		input logic [15:0] prio);
		while ((idle_mode == 1 && $urandom_range(99) < 87) ||
			(idle_mode == 3 && $urandom_range(99) < 19)) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		action = act;
		stream_id = sid;
		produced = prod;
		payload_length = plen;
		is_end = endm;
		bytes_next = nxt;
		priority_req = prio;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		last_action = act;
	endtask

	task automatic send_random();
		logic [1:0]  act;
		logic [31:0] nxt;
		int          pick;
		pick = $urandom_range(99);
		if (last_action == ACT_SELECT && pick < 70)
			act = ACT_REPORT;
		else if (pick < 40)
			act = ACT_SELECT;
		else if (pick < 70)
			act = ACT_DREADY;
		else if (pick < 85)
			act = ACT_REPORT;
		else
			act = ACT_SETPRI;
		case ($urandom_range(3))
		0: nxt = '0;
		1: nxt = $urandom_range(2000, 1);
		2: nxt = $urandom;
		default: nxt = $urandom_range(64, 1);
		endcase
		send_req(act, 4'($urandom_range(15)), $urandom_range(99) < 85,
			($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1500)),
			1'($urandom_range(1)), nxt,
			($urandom_range(3) == 0) ? 16'($urandom_range(3)) : 16'($urandom));
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] val);
		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (30) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	initial begin
		logic        ilv[8] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
		logic [15:0] cap[8] = '{16'd1200, 16'd1200, 16'd1, 16'd65535, 16'd0, 16'd0,
			16'd65535, 16'd300};
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		send_req(ACT_SELECT, 4'd0, 1'b0, 16'd0, 1'b0, 32'd0, 16'd0);
		send_req(ACT_REPORT, 4'd0, 1'b1, 16'd10, 1'b1, 32'd5, 16'd0);
		send_req(ACT_SETPRI, 4'd0, 1'b0, 16'd0, 1'b0, 32'd0, 16'd0);
		send_req(ACT_SETPRI, 4'd15, 1'b0, 16'd0, 1'b0, 32'd0, 16'd1);
		send_req(ACT_SETPRI, 4'd3, 1'b0, 16'd0, 1'b0, 32'd0, 16'd65535);
		send_req(ACT_DREADY, 4'd0, 1'b0, 16'd0, 1'b0, 32'd0, 16'd0);
		send_req(ACT_DREADY, 4'd0, 1'b0, 16'd0, 1'b0, 32'hFFFF_FFFF, 16'd0);
		send_req(ACT_DREADY, 4'd15, 1'b0, 16'd0, 1'b0, 32'd1, 16'd0);
		send_req(ACT_DREADY, 4'd3, 1'b0, 16'd0, 1'b0, 32'd100, 16'd0);
		send_req(ACT_DREADY, 4'd0, 1'b0, 16'd0, 1'b0, 32'd7, 16'd0);
		send_req(ACT_SELECT, 4'd0, 1'b0, 16'd0, 1'b0, 32'd0, 16'd0);
		send_req(ACT_REPORT, 4'd0, 1'b0, 16'd0, 1'b0, 32'd0, 16'd0);
		send_req(ACT_REPORT, 4'd0, 1'b1, 16'hFFFF, 1'b0, 32'd5, 16'd0);
		send_req(ACT_SELECT, 4'd0, 1'b0, 16'd0, 1'b0, 32'd0, 16'd0);
		send_req(ACT_REPORT, 4'd0, 1'b1, 16'd0, 1'b1, 32'd0, 16'd0);
		send_req(ACT_SELECT, 4'd0, 1'b0, 16'd0, 1'b0, 32'd0, 16'd0);
		send_req(ACT_REPORT, 4'd0, 1'b1, 16'd1, 1'b1, 32'd9, 16'd0);
		send_req(ACT_DREADY, 4'd7, 1'b0, 16'd0, 1'b0, 32'd3, 16'd0);
		send_req(ACT_REPORT, 4'd0, 1'b1, 16'd2, 1'b0, 32'd4, 16'd0);
		send_req(ACT_SELECT, 4'd0, 1'b0, 16'd0, 1'b0, 32'd0, 16'd0);
		send_req(ACT_SELECT, 4'd0, 1'b0, 16'd0, 1'b0, 32'd0, 16'd0);
		send_req(ACT_SELECT, 4'd0, 1'b0, 16'd0, 1'b0, 32'd0, 16'd0);

		for (int ph = 0; ph < 8; ph++) begin
			if (ph > 0) begin
				write_reg(REG_INTERLEAVE, {15'd0, ilv[ph]});
				write_reg(REG_MAX_PAYLOAD, cap[ph]);
			end
			idle_mode = ph % 4;
			for (int k = 0; k < 200; k++)
				send_random();
		end

		in_valid = 1'b0;
		idle_mode = 0;
		while (pending != 0)
			@(negedge clk);
		repeat (50) @(negedge clk);
		if (err_count == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
